FILE: rtl/transform_matrix_accumulator_core_macros.svh
// Assertion macros used by the transform matrix accumulator core.
`ifndef TRANSFORM_MATRIX_ACCUMULATOR_CORE_MACROS_SVH
`define TRANSFORM_MATRIX_ACCUMULATOR_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define TMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, outside reset.
`define TMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tma_pkg.sv
// Package with types, codes and arithmetic helpers of the transform matrix accumulator.
`default_nettype none
package tma_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int DATA_W = 32;
  localparam int N = 4;
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) <<< FRACTION_BITS;

  // A shifted product needs 2*DATA_W-FRACTION_BITS bits; four of them need two more.
  localparam int ACC_W = 2*DATA_W - FRACTION_BITS + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh80000000);

  localparam logic [2:0] OP_IDENTITY  = 3'd0;
  localparam logic [2:0] OP_TRANSLATE = 3'd1;
  localparam logic [2:0] OP_SCALE     = 3'd2;
  localparam logic [2:0] OP_LOAD      = 3'd3;
  localparam logic [2:0] OP_MULTIPLY  = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] group_index;
    word_t      value_a;
    word_t      value_b;
    word_t      value_c;
    word_t      value_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0] read_group;
    word_t      entry_zero;
    word_t      entry_one;
    word_t      entry_two;
    word_t      entry_three;
  } out_item_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic       set_id;    // load identity column
    logic       mac_clr;   // start of a new sum
    logic       mac_en;    // one product step
    logic       commit;    // write finished sums
    logic [1:0] k;         // term index of this step
  } cell_ctl_t;

  // Saturate an accumulated sum to 32 bits.
  function automatic word_t sat32(input logic signed [ACC_W-1:0] x);
    word_t r;
    if (x > SAT_HI) r = {1'b0, {(DATA_W-1){1'b1}}};
    else if (x < SAT_LO) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = x[DATA_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/transform_matrix_accumulator_core.sv
// Top level of the transform matrix accumulator: sequencer, staging store and four column cells.
//
//  channel | ports                      | handshake
//  input   | in_start, in_busy, in_item | accepted when in_start and not in_busy
//  result  | out_valid, out_item        | one-cycle strobe, cannot be stalled
//
// A translate, scale or multiply runs four product steps shared
// by the four cells, one step per term k, then the accumulate and write stages.
// Identity and load take effect when accepted; a read result appears the cycle after.
// Synchronous active-low reset sets both matrices to identity.
// busy is high whenever the sequencer is not idle; the receiver cannot stall.
`default_nettype none
module transform_matrix_accumulator_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_start,
  output logic                     in_busy,
  input  wire tma_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output tma_pkg::out_item_t       out_item
);
  import tma_pkg::*;
  `include "transform_matrix_accumulator_core_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  word_t s_r [16];
  word_t t_r [16];
  word_t col_q [4][4];
  word_t t_row [4];
  cell_ctl_t ctl;
  logic accept;

  assign accept = in_start && !in_busy;
  assign in_busy = (state_r != ST_IDLE);

  always_comb begin
    for (int r = 0; r < N; r++) t_row[r] = t_r[{step_r[1:0], 2'(r)}];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    ctl = '0;
    ctl.k = step_r[1:0];
    case (state_r)
      ST_IDLE: begin
        ctl.set_id = accept && (in_item.opcode == OP_IDENTITY);
        if (accept && (in_item.opcode == OP_TRANSLATE || in_item.opcode == OP_SCALE ||
                       in_item.opcode == OP_MULTIPLY)) begin
          state_nxt = ST_RUN;
          step_nxt = '0;
          ctl.mac_clr = 1'b1;
        end
      end
      ST_RUN: begin
        ctl.mac_en = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd3) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Last product lands in the accumulator this cycle; commit next.
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          ctl.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) s_r[i] <= (i % 5 == 0) ? FX_ONE : '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      out_valid <= accept && (in_item.opcode == OP_READ);
      if (accept && in_item.opcode == OP_LOAD) begin
        s_r[{in_item.group_index, 2'd0}] <= in_item.value_a;
        s_r[{in_item.group_index, 2'd1}] <= in_item.value_b;
        s_r[{in_item.group_index, 2'd2}] <= in_item.value_c;
        s_r[{in_item.group_index, 2'd3}] <= in_item.value_d;
      end
    end
  end

  // Operand matrix captured when a transform starts: the staging store for a multiply, else built from the item.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && state_nxt == ST_RUN) begin
      if (in_item.opcode == OP_MULTIPLY) begin
        t_r <= s_r;
      end else begin
        for (int i = 0; i < 16; i++) t_r[i] <= (i % 5 == 0) ? FX_ONE : '0;
        if (in_item.opcode == OP_TRANSLATE) begin
          t_r[12] <= in_item.value_a;
          t_r[13] <= in_item.value_b;
          t_r[14] <= in_item.value_c;
        end else begin
          t_r[0]  <= in_item.value_a;
          t_r[5]  <= in_item.value_b;
          t_r[10] <= in_item.value_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.opcode == OP_READ) begin
      out_item.read_group  <= in_item.group_index;
      out_item.entry_zero  <= col_q[in_item.group_index][0];
      out_item.entry_one   <= col_q[in_item.group_index][1];
      out_item.entry_two   <= col_q[in_item.group_index][2];
      out_item.entry_three <= col_q[in_item.group_index][3];
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_cell
    tma_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .col       (2'(c)),
      .t_row     (t_row),
      .from_prev (col_q[(c + N - 1) % N]),
      .col_q     (col_q[c])
    );
  end

  `TMA_ASSERT_IMP(a_commit_done, clk, rst_n, ctl.commit, state_r == ST_DONE, "commit outside done")
  `TMA_ASSERT_NEXT(a_read_strobe, clk, rst_n, accept && in_item.opcode == OP_READ, out_valid, "read lost")
  `TMA_ASSERT_IMP(a_no_out_busy, clk, rst_n, out_valid, !$past(in_busy), "result during multiply")
  `TMA_ASSERT_IMP(a_step_range, clk, rst_n, state_r == ST_RUN, step_r < 3'd4, "step overrun")
endmodule
`default_nettype wire

FILE: rtl/tma_cell.sv
// One column cell: holds a column of M and computes its new column over four steps.
`default_nettype none
module tma_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire tma_pkg::cell_ctl_t ctl,
  input  wire [1:0]               col,
  input  wire tma_pkg::word_t     t_row [4],    // T[k*4+r] for r = 0..3 at step k
  input  wire tma_pkg::word_t     from_prev [4],
  output tma_pkg::word_t          col_q [4]
);
  import tma_pkg::*;

  word_t m_r [4];
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [2*DATA_W-1:0] prod_r [4];
  logic pvalid_r;
  word_t mk;

  assign col_q = m_r;
  assign mk = m_r[ctl.k];

  // One product per row each step; registered before accumulation.
  always_ff @(posedge clk) begin
    for (int r = 0; r < N; r++) prod_r[r] <= t_row[r] * mk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
      for (int r = 0; r < N; r++) begin
        m_r[r] <= (r == int'(col)) ? FX_ONE : '0;
        acc_r[r] <= '0;
      end
    end else begin
      pvalid_r <= ctl.mac_en;
      if (ctl.mac_clr) begin
        for (int r = 0; r < N; r++) acc_r[r] <= '0;
      end else if (pvalid_r) begin
        for (int r = 0; r < N; r++)
          acc_r[r] <= acc_r[r] + ACC_W'(prod_r[r] >>> FRACTION_BITS);
      end
      if (ctl.set_id) begin
        for (int r = 0; r < N; r++) m_r[r] <= (r == int'(col)) ? FX_ONE : '0;
      end else if (ctl.commit) begin
        for (int r = 0; r < N; r++) m_r[r] <= sat32(acc_r[r]);
      end
    end
  end

  // The neighbor's column is seen so the chain is complete; it feeds nothing else.
  logic unused_prev;
  assign unused_prev = ^{from_prev[0], from_prev[1], from_prev[2], from_prev[3]};
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the transform matrix accumulator core.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tma_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic in_start;
  logic in_busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;

  transform_matrix_accumulator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state.
  word_t xform_m[16];
  word_t stage_m[16];
  out_item_t pending_reads[$];
  int error_count;
  int reads_checked;
  int items_sent;
  int op_seen[8];

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic word_t fx_floor_mac(input word_t t0, input word_t m0, input word_t t1,
                                         input word_t m1, input word_t t2, input word_t m2,
                                         input word_t t3, input word_t m3);
    logic signed [63:0] p0, p1, p2, p3;
    logic signed [67:0] acc;
    p0 = 64'(t0) * 64'(m0);
    p1 = 64'(t1) * 64'(m1);
    p2 = 64'(t2) * 64'(m2);
    p3 = 64'(t3) * 64'(m3);
    // Arithmetic shift rounds toward minus infinity.
    acc = 68'(p0 >>> FRACTION_BITS) + 68'(p1 >>> FRACTION_BITS)
        + 68'(p2 >>> FRACTION_BITS) + 68'(p3 >>> FRACTION_BITS);
    if (acc > 68'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (acc < -68'sh080000000) return 32'sh80000000;
    return acc[31:0];
  endfunction

  task automatic transform_by(input word_t t[16]);
    word_t nxt[16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        nxt[c*4+r] = fx_floor_mac(t[r], xform_m[c*4], t[4+r], xform_m[c*4+1],
                                  t[8+r], xform_m[c*4+2], t[12+r], xform_m[c*4+3]);
    xform_m = nxt;
  endtask

  function automatic void make_identity(output word_t m[16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? FX_ONE : '0;
  endfunction

  function automatic out_item_t predict_read(input logic [1:0] g);
    out_item_t r;
    r.read_group  = g;
    r.entry_zero  = xform_m[g*4];
    r.entry_one   = xform_m[g*4+1];
    r.entry_two   = xform_m[g*4+2];
    r.entry_three = xform_m[g*4+3];
    return r;
  endfunction

  task automatic predict_item(input in_item_t it);
    word_t t[16];
    op_seen[it.opcode]++;
    make_identity(t);
    case (it.opcode)
      OP_IDENTITY: begin
        make_identity(xform_m);
      end
      OP_TRANSLATE: begin
        t[12] = it.value_a; t[13] = it.value_b; t[14] = it.value_c;
        transform_by(t);
      end
      OP_SCALE: begin
        t[0] = it.value_a; t[5] = it.value_b; t[10] = it.value_c;
        transform_by(t);
      end
      OP_LOAD: begin
        stage_m[it.group_index*4]   = it.value_a;
        stage_m[it.group_index*4+1] = it.value_b;
        stage_m[it.group_index*4+2] = it.value_c;
        stage_m[it.group_index*4+3] = it.value_d;
      end
      OP_MULTIPLY: begin
        transform_by(stage_m);
      end
      OP_READ: begin
        pending_reads.push_back(predict_read(it.group_index));
      end
      default: ;
    endcase
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        $display("UNEXPECTED result at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (out_item.read_group != want.read_group)
          report_mismatch("read_group", word_t'(out_item.read_group),
                          word_t'(want.read_group));
        if (out_item.entry_zero != want.entry_zero)
          report_mismatch("entry_zero", out_item.entry_zero, want.entry_zero);
        if (out_item.entry_one != want.entry_one)
          report_mismatch("entry_one", out_item.entry_one, want.entry_one);
        if (out_item.entry_two != want.entry_two)
          report_mismatch("entry_two", out_item.entry_two, want.entry_two);
        if (out_item.entry_three != want.entry_three)
          report_mismatch("entry_three", out_item.entry_three, want.entry_three);
      end
    end
  end

  // Drives one item from the falling edge and holds it until accepted.
  task automatic send_item(input in_item_t it);
    bit taken;
    int gap;
    in_item <= it;
    in_start <= 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_busy;
      @(negedge clk);
    end
    predict_item(it);
    items_sent++;
    gap = $urandom_range(0, 15);
    // With no gap, start stays high and the next item follows directly.
    if (gap != 0) begin
      in_start <= 1'b0;
      in_item <= in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom}));
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return FX_ONE;
      3: return -FX_ONE;
      4: return '0;
      5, 6: return word_t'($urandom);
      default: return word_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [2:0] op, input logic [1:0] g,
                                         input word_t a, input word_t b,
                                         input word_t c, input word_t d);
    in_item_t it;
    it.opcode = op; it.group_index = g;
    it.value_a = a; it.value_b = b; it.value_c = c; it.value_d = d;
    return it;
  endfunction

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(input in_item_t it, input bit fixed, input out_item_t res);
    stim_row_t row;
    row.item = it; row.fixed = fixed; row.result = res;
    directed.push_back(row);
  endtask

  initial begin
    word_t big, neg;
    out_item_t none;
    none = '0;
    big = 32'sh7FFFFFFF;
    neg = 32'sh80000000;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_item = '0;
    error_count = 0;
    reads_checked = 0;
    items_sent = 0;
    make_identity(xform_m);
    make_identity(stage_m);

    // Identity after reset, then extremes that saturate, unused opcodes, and loads and multiplies.
    add_row(make_item(OP_READ, 2'd0, 0, 0, 0, 0), 1, '{2'd0, FX_ONE, 0, 0, 0});
    add_row(make_item(OP_READ, 2'd3, big, neg, big, neg), 1, '{2'd3, 0, 0, 0, FX_ONE});
    add_row(make_item(OP_TRANSLATE, 2'd1, big, neg, 32'sh00018000, big), 0, none);
    add_row(make_item(OP_READ, 2'd3, 0, 0, 0, 0), 1,
            '{2'd3, big, neg, 32'sh00018000, FX_ONE});
    add_row(make_item(3'd6, 2'd2, big, big, big, big), 0, none);
    add_row(make_item(3'd7, 2'd1, neg, neg, neg, neg), 0, none);
    add_row(make_item(OP_READ, 2'd1, 0, 0, 0, 0), 1, '{2'd1, 0, FX_ONE, 0, 0});
    add_row(make_item(OP_SCALE, 2'd0, big, neg, -FX_ONE, 0), 0, none);
    add_row(make_item(OP_READ, 2'd3, 0, 0, 0, 0), 0, none);
    add_row(make_item(OP_READ, 2'd0, 0, 0, 0, 0), 0, none);
    add_row(make_item(OP_IDENTITY, 2'd3, big, big, big, big), 0, none);
    add_row(make_item(OP_READ, 2'd2, 0, 0, 0, 0), 1, '{2'd2, 0, 0, FX_ONE, 0});
    for (int g = 0; g < 4; g++)
      add_row(make_item(OP_LOAD, 2'(g), big, neg, -1, 32'sh00020000), 0, none);
    add_row(make_item(OP_MULTIPLY, 2'd0, 0, 0, 0, 0), 0, none);
    add_row(make_item(OP_MULTIPLY, 2'd2, 0, 0, 0, 0), 0, none);
    for (int g = 0; g < 4; g++)
      add_row(make_item(OP_READ, 2'(g), 0, 0, 0, 0), 0, none);
    add_row(make_item(OP_SCALE, 2'd0, -1, 1, neg, 0), 0, none);
    add_row(make_item(OP_READ, 2'd1, 0, 0, 0, 0), 0, none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      // Spot values typed in by hand must agree with the predictor too.
      if (directed[i].fixed &&
          predict_read(directed[i].item.group_index) != directed[i].result) begin
        $display("MISMATCH directed row %0d disagrees with hand value", i);
        error_count++;
      end
      send_item(directed[i].item);
    end

    // Reads are the most frequent, then loads, with the other opcodes mixed in; a few
    // identities keep values from staying pinned at the rails.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = OP_IDENTITY;
      else if (pick < 17) op = OP_TRANSLATE;
      else if (pick < 29) op = OP_SCALE;
      else if (pick < 52) op = OP_LOAD;
      else if (pick < 64) op = OP_MULTIPLY;
      else if (pick < 97) op = OP_READ;
      else op = 3'($urandom_range(6, 7));
      send_item(make_item(op, 2'($urandom_range(0, 3)), pick_value(), pick_value(),
                          pick_value(), pick_value()));
    end
    in_start <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (identity %0d, translate %0d, scale %0d, load %0d,",
             items_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("  multiply %0d, read %0d, unused %0d); %0d group reads checked.",
             op_seen[4], op_seen[5], op_seen[6] + op_seen[7], reads_checked);
    if (error_count == 0) begin
      $display("transform_matrix_accumulator_core verification clean");
    end else begin
      $display("transform_matrix_accumulator_core verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", pending_reads.size());
    $display("transform_matrix_accumulator_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire
